// ===== sv/ssd_pkg.sv =====
// Shared constants and types for the segment-to-segment distance block.
// No dependencies; every other source file depends on this package.
package ssd_pkg;

  localparam int COORD_BITS_DEF = 24;
  localparam int OUT_W          = 25;
  localparam int SC_FRAC        = 32;
  localparam int QW             = SC_FRAC + 1;
  localparam int FIFO_DEPTH     = 4;
  localparam logic [OUT_W-1:0] OUT_MAX = '1;

  // queue status seen by the front and back parts
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // width of the dot products a..e
  function automatic int ssd_dw(input int c);
    return 2 * c + 4;
  endfunction

  // width of D, the numerators and the denominators
  function automatic int ssd_pw(input int c);
    return 2 * ssd_dw(c) + 2;
  endfunction

  // width of one queue word: sn, sd, tn, td and the nine u/v/w components
  function automatic int ssd_ew(input int c);
    return 4 * ssd_pw(c) + 9 * (c + 1);
  endfunction

endpackage

// ===== sv/ssd_if.sv =====
// Valid/ready channel interfaces for segment pairs and distance results.
// Depends on ssd_pkg for the coordinate default and the result width.
interface ssd_in_if #(parameter int COORD_BITS = ssd_pkg::COORD_BITS_DEF);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] seg_a_start_x;
  logic signed [COORD_BITS-1:0] seg_a_start_y;
  logic signed [COORD_BITS-1:0] seg_a_start_z;
  logic signed [COORD_BITS-1:0] seg_a_end_x;
  logic signed [COORD_BITS-1:0] seg_a_end_y;
  logic signed [COORD_BITS-1:0] seg_a_end_z;
  logic signed [COORD_BITS-1:0] seg_b_start_x;
  logic signed [COORD_BITS-1:0] seg_b_start_y;
  logic signed [COORD_BITS-1:0] seg_b_start_z;
  logic signed [COORD_BITS-1:0] seg_b_end_x;
  logic signed [COORD_BITS-1:0] seg_b_end_y;
  logic signed [COORD_BITS-1:0] seg_b_end_z;

  modport source (output valid, seg_a_start_x, seg_a_start_y, seg_a_start_z,
                  seg_a_end_x, seg_a_end_y, seg_a_end_z, seg_b_start_x, seg_b_start_y,
                  seg_b_start_z, seg_b_end_x, seg_b_end_y, seg_b_end_z, input ready);
  modport sink (input valid, seg_a_start_x, seg_a_start_y, seg_a_start_z,
                seg_a_end_x, seg_a_end_y, seg_a_end_z, seg_b_start_x, seg_b_start_y,
                seg_b_start_z, seg_b_end_x, seg_b_end_y, seg_b_end_z, output ready);
endinterface

interface ssd_out_if;
  logic                        valid;
  logic                        ready;
  logic [ssd_pkg::OUT_W-1:0]   closest_distance;

  modport source (output valid, closest_distance, input ready);
  modport sink (input valid, closest_distance, output ready);
endinterface

// ===== sv/segment_segment_distance_top.sv =====
// Top level of the closest-distance-between-segments block.
// Depends on ssd_pkg, ssd_if, ssd_front, ssd_fifo and ssd_back.
//
//   channel  dir  word                              accepted when
//   in_ch    in   twelve Q15.8 endpoint coordinates  valid && ready
//   out_ch   out  closest_distance, Q17.8 unsigned   valid && ready
//
// One pair enters per cycle while in_ch.ready is high. An accepted pair passes
// through 6 front stages, one queue write and QW + 6 + (COORD_BITS + 5) = 68 back
// stages before out_ch.valid rises; the depth comes from the split wide products,
// the one-bit-per-stage dividers for sc and tc and the one-bit-per-stage root.
// Reset clears only valid bits, queue pointers and the queue count.
// A stalled output holds the back pipe; the 4-word queue then fills before the
// front pipe and in_ch.ready drop.
module segment_segment_distance_top import ssd_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  ssd_in_if.sink    in_ch,
  ssd_out_if.source out_ch
);

  localparam int EW = ssd_ew(COORD_BITS);

  logic          push, pop;
  logic [EW-1:0] push_data, pop_data;
  q_stat_t       q_stat;

  ssd_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data)
  );

  ssd_fifo #(.WIDTH(EW)) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .stat      (q_stat)
  );

  ssd_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_stat   (q_stat),
    .pop_data (pop_data),
    .pop      (pop),
    .out_ch   (out_ch)
  );

endmodule

// ===== sv/ssd_front.sv =====
// Front part: forms u, v, w, the dot products, D and the numerators, then clamps.
// Depends on ssd_pkg and ssd_in_if; pushes one word per pair into the queue.
module ssd_front import ssd_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  ssd_in_if.sink                        in_ch,
  input  q_stat_t                       q_stat,
  output logic                          push,
  output logic [ssd_ew(COORD_BITS)-1:0] push_data
);

  localparam int DIF = COORD_BITS + 1;
  localparam int DW  = ssd_dw(COORD_BITS);
  localparam int PW  = ssd_pw(COORD_BITS);
  localparam int UVW = 9 * DIF;
  localparam int HW  = DW / 2;
  localparam int PPW = 2 * HW + 2;

  logic en;
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  logic [UVW-1:0] uvw1_r, uvw2_r, uvw3_r, uvw4_r, uvw5_r, uvw6_r;

  logic signed [DIF-1:0] as [3];
  logic signed [DIF-1:0] ae [3];
  logic signed [DIF-1:0] bs [3];
  logic signed [DIF-1:0] be [3];

  logic signed [2*DIF-1:0] uu_r [3];
  logic signed [2*DIF-1:0] uv_r [3];
  logic signed [2*DIF-1:0] vv_r [3];
  logic signed [2*DIF-1:0] uw_r [3];
  logic signed [2*DIF-1:0] vw_r [3];

  logic signed [DW-1:0] a3_r, b3_r, c3_r, d3_r, e3_r;
  logic signed [DW-1:0] a4_r, b4_r, c4_r, d4_r, e4_r;
  logic signed [DW-1:0] a5_r, b5_r, c5_r, d5_r, e5_r;
  logic signed [DW-1:0] a6_r, b6_r, c6_r, d6_r, e6_r;

  // products in order: a*c, b*b, b*e, c*d, a*e, b*d
  logic signed [DW-1:0]  mx [6];
  logic signed [DW-1:0]  my [6];
  logic signed [HW:0]    xh [6];
  logic signed [HW:0]    xl [6];
  logic signed [HW:0]    yh [6];
  logic signed [HW:0]    yl [6];
  logic signed [PPW-1:0] pp_hh_r [6];
  logic signed [PPW-1:0] pp_hl_r [6];
  logic signed [PPW-1:0] pp_lh_r [6];
  logic signed [PPW-1:0] pp_ll_r [6];
  logic signed [PW-1:0]  prod_r [6];
  logic signed [PW-1:0]  dd6_r, sn6_r, tn6_r;

  assign en       = !v6_r || !q_stat.full;
  assign push     = v6_r && !q_stat.full;
  assign in_ch.ready = en;

  assign as[0] = DIF'(in_ch.seg_a_start_x);
  assign as[1] = DIF'(in_ch.seg_a_start_y);
  assign as[2] = DIF'(in_ch.seg_a_start_z);
  assign ae[0] = DIF'(in_ch.seg_a_end_x);
  assign ae[1] = DIF'(in_ch.seg_a_end_y);
  assign ae[2] = DIF'(in_ch.seg_a_end_z);
  assign bs[0] = DIF'(in_ch.seg_b_start_x);
  assign bs[1] = DIF'(in_ch.seg_b_start_y);
  assign bs[2] = DIF'(in_ch.seg_b_start_z);
  assign be[0] = DIF'(in_ch.seg_b_end_x);
  assign be[1] = DIF'(in_ch.seg_b_end_y);
  assign be[2] = DIF'(in_ch.seg_b_end_z);

  // split each wide operand into a signed high half and an unsigned low half
  always_comb begin
    mx[0] = a3_r;
    my[0] = c3_r;
    mx[1] = b3_r;
    my[1] = b3_r;
    mx[2] = b3_r;
    my[2] = e3_r;
    mx[3] = c3_r;
    my[3] = d3_r;
    mx[4] = a3_r;
    my[4] = e3_r;
    mx[5] = b3_r;
    my[5] = d3_r;
    for (int i = 0; i < 6; i++) begin
      xh[i] = (HW+1)'(signed'(mx[i][DW-1:HW]));
      xl[i] = signed'({1'b0, mx[i][HW-1:0]});
      yh[i] = (HW+1)'(signed'(my[i][DW-1:HW]));
      yl[i] = signed'({1'b0, my[i][HW-1:0]});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_ch.valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // u at slot k, v at slot 3+k, w at slot 6+k
      for (int k = 0; k < 3; k++) begin
        uvw1_r[k*DIF +: DIF]     <= ae[k] - as[k];
        uvw1_r[(3+k)*DIF +: DIF] <= be[k] - bs[k];
        uvw1_r[(6+k)*DIF +: DIF] <= as[k] - bs[k];
      end
      for (int k = 0; k < 3; k++) begin
        uu_r[k] <= signed'(uvw1_r[k*DIF +: DIF]) * signed'(uvw1_r[k*DIF +: DIF]);
        uv_r[k] <= signed'(uvw1_r[k*DIF +: DIF]) * signed'(uvw1_r[(3+k)*DIF +: DIF]);
        vv_r[k] <= signed'(uvw1_r[(3+k)*DIF +: DIF]) * signed'(uvw1_r[(3+k)*DIF +: DIF]);
        uw_r[k] <= signed'(uvw1_r[k*DIF +: DIF]) * signed'(uvw1_r[(6+k)*DIF +: DIF]);
        vw_r[k] <= signed'(uvw1_r[(3+k)*DIF +: DIF]) * signed'(uvw1_r[(6+k)*DIF +: DIF]);
      end
      uvw2_r <= uvw1_r;
      a3_r   <= DW'(uu_r[0]) + DW'(uu_r[1]) + DW'(uu_r[2]);
      b3_r   <= DW'(uv_r[0]) + DW'(uv_r[1]) + DW'(uv_r[2]);
      c3_r   <= DW'(vv_r[0]) + DW'(vv_r[1]) + DW'(vv_r[2]);
      d3_r   <= DW'(uw_r[0]) + DW'(uw_r[1]) + DW'(uw_r[2]);
      e3_r   <= DW'(vw_r[0]) + DW'(vw_r[1]) + DW'(vw_r[2]);
      uvw3_r <= uvw2_r;
      // half-width partial products, then recombine one stage later
      for (int i = 0; i < 6; i++) begin
        pp_hh_r[i] <= PPW'(xh[i]) * PPW'(yh[i]);
        pp_hl_r[i] <= PPW'(xh[i]) * PPW'(yl[i]);
        pp_lh_r[i] <= PPW'(xl[i]) * PPW'(yh[i]);
        pp_ll_r[i] <= PPW'(xl[i]) * PPW'(yl[i]);
        prod_r[i]  <= (PW'(pp_hh_r[i]) <<< (2*HW)) +
                      ((PW'(pp_hl_r[i]) + PW'(pp_lh_r[i])) <<< HW) + PW'(pp_ll_r[i]);
      end
      a4_r   <= a3_r;
      b4_r   <= b3_r;
      c4_r   <= c3_r;
      d4_r   <= d3_r;
      e4_r   <= e3_r;
      uvw4_r <= uvw3_r;
      a5_r   <= a4_r;
      b5_r   <= b4_r;
      c5_r   <= c4_r;
      d5_r   <= d4_r;
      e5_r   <= e4_r;
      uvw5_r <= uvw4_r;
      dd6_r  <= prod_r[0] - prod_r[1];
      sn6_r  <= prod_r[2] - prod_r[3];
      tn6_r  <= prod_r[4] - prod_r[5];
      a6_r   <= a5_r;
      b6_r   <= b5_r;
      c6_r   <= c5_r;
      d6_r   <= d5_r;
      e6_r   <= e5_r;
      uvw6_r <= uvw5_r;
    end
  end

  // clamp the numerators to the segment ends
  logic signed [PW-1:0] sn, sd, tn, td, m, pa, pb, pc, pd, pe;
  logic                 redo_s;

  always_comb begin
    pa = PW'(a6_r);
    pb = PW'(b6_r);
    pc = PW'(c6_r);
    pd = PW'(d6_r);
    pe = PW'(e6_r);
    if (dd6_r <= 0) begin
      sn = '0;
      sd = PW'(1);
      tn = pe;
      td = pc;
    end else begin
      sd = dd6_r;
      td = dd6_r;
      sn = sn6_r;
      tn = tn6_r;
      if (sn6_r < 0) begin
        sn = '0;
        tn = pe;
        td = pc;
      end else if (sn6_r > dd6_r) begin
        sn = dd6_r;
        tn = pe + pb;
        td = pc;
      end
    end
    redo_s = 1'b0;
    m      = -pd;
    if (tn < 0) begin
      tn     = '0;
      redo_s = 1'b1;
    end else if (tn > td) begin
      tn     = td;
      m      = pb - pd;
      redo_s = 1'b1;
    end
    if (redo_s) begin
      if (m < 0) begin
        sn = '0;
      end else if (m > pa) begin
        sn = sd;
      end else begin
        sn = m;
        sd = pa;
      end
    end
    push_data = {sn, sd, tn, td, uvw6_r};
  end

endmodule

// ===== sv/ssd_fifo.sv =====
// Short queue that decouples the front part from the back part.
// Depends on ssd_pkg for the depth and the status struct.
module ssd_fifo import ssd_pkg::*; #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output q_stat_t          stat
);

  localparam int AW = $clog2(FIFO_DEPTH);

  logic [WIDTH-1:0] mem [FIFO_DEPTH];
  logic [AW-1:0]    wp_r, rp_r;
  logic [AW:0]      cnt_r;

  assign stat.full  = (cnt_r == (AW+1)'(FIFO_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign pop_data   = mem[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= rp_r + 1'b1;
      end
      cnt_r <= cnt_r + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

  a_no_pop_empty : assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !stat.empty) else $error("queue popped while empty");
  a_no_push_full : assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !stat.full) else $error("queue pushed while full");
  a_cnt_up : assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> cnt_r == $past(cnt_r) + 1'b1) else $error("queue count lost a word");
  a_cnt_max : assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (AW+1)'(FIFO_DEPTH)) else $error("queue count beyond depth");

endmodule

// ===== sv/ssd_back.sv =====
// Back part: divides out sc and tc, builds the closest vector and takes its root.
// Depends on ssd_pkg and ssd_out_if; pulls words from the queue.
module ssd_back import ssd_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  q_stat_t                       q_stat,
  input  logic [ssd_ew(COORD_BITS)-1:0] pop_data,
  output logic                          pop,
  ssd_out_if.source                     out_ch
);

  localparam int DIF = COORD_BITS + 1;
  localparam int PW  = ssd_pw(COORD_BITS);
  localparam int UVW = 9 * DIF;
  localparam int MW  = DIF + QW + 1;
  localparam int PKW = COORD_BITS + 4;
  localparam int SW  = 2 * PKW + 2;
  localparam int NR  = SW / 2;

  logic enb;
  logic out_valid_r;
  logic [OUT_W-1:0] out_data_r;

  assign enb          = !out_valid_r || out_ch.ready;
  assign pop          = enb && !q_stat.empty;
  assign out_ch.valid = out_valid_r;
  assign out_ch.closest_distance = out_data_r;

  // unpack the queue word
  logic signed [PW-1:0] sn, sd, tn, td;
  logic [UVW-1:0]       uvw;
  logic                 zs, zt;

  assign {sn, sd, tn, td, uvw} = pop_data;
  assign zs = (sn <= 0) || (sd <= 0);
  assign zt = (tn <= 0) || (td <= 0);

  // divider stages, one quotient bit each
  logic [PW:0]     rs_r  [QW+1];
  logic [PW:0]     rt_r  [QW+1];
  logic [PW-1:0]   ds_r  [QW+1];
  logic [PW-1:0]   dt_r  [QW+1];
  logic [QW-1:0]   qs_r  [QW+1];
  logic [QW-1:0]   qt_r  [QW+1];
  logic [UVW-1:0]  uvwd_r[QW+1];
  logic [QW:0]     vd_r;

  always_ff @(posedge clk) begin
    if (enb) begin
      // a zero or negative term divides 0 by 1
      rs_r[0]   <= zs ? '0 : {1'b0, sn};
      ds_r[0]   <= zs ? PW'(1) : sd;
      rt_r[0]   <= zt ? '0 : {1'b0, tn};
      dt_r[0]   <= zt ? PW'(1) : td;
      qs_r[0]   <= '0;
      qt_r[0]   <= '0;
      uvwd_r[0] <= uvw;
    end
  end

  for (genvar k = 1; k <= QW; k++) begin : g_div
    localparam int BI = QW - k;
    logic [PW:0]   rsh, rth;
    logic          ges, get;
    logic [QW-1:0] qsn, qtn;

    always_comb begin
      if (k == 1) begin
        rsh = rs_r[k-1];
        rth = rt_r[k-1];
      end else begin
        rsh = {rs_r[k-1][PW-1:0], 1'b0};
        rth = {rt_r[k-1][PW-1:0], 1'b0};
      end
      ges = rsh >= {1'b0, ds_r[k-1]};
      get = rth >= {1'b0, dt_r[k-1]};
      qsn = qs_r[k-1];
      qtn = qt_r[k-1];
      qsn[BI] = ges;
      qtn[BI] = get;
    end

    always_ff @(posedge clk) begin
      if (enb) begin
        rs_r[k]   <= ges ? rsh - {1'b0, ds_r[k-1]} : rsh;
        rt_r[k]   <= get ? rth - {1'b0, dt_r[k-1]} : rth;
        ds_r[k]   <= ds_r[k-1];
        dt_r[k]   <= dt_r[k-1];
        qs_r[k]   <= qsn;
        qt_r[k]   <= qtn;
        uvwd_r[k] <= uvwd_r[k-1];
      end
    end
  end

  // closest vector: w + u*sc - v*tc, then drop the fraction
  logic signed [MW-1:0]    us_r [3];
  logic signed [MW-1:0]    vt_r [3];
  logic signed [DIF-1:0]   wm_r [3];
  logic signed [PKW-1:0]   p_r  [3];
  logic signed [2*PKW-1:0] sq_r [3];
  logic vm_r, va_r, vs_r;

  logic signed [MW+1:0] acc  [3];
  logic signed [MW+1:0] accs [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      acc[k]  = ((MW+2)'(wm_r[k]) <<< SC_FRAC) + (MW+2)'(us_r[k]) - (MW+2)'(vt_r[k]);
      accs[k] = acc[k] >>> SC_FRAC;
    end
  end

  always_ff @(posedge clk) begin
    if (enb) begin
      for (int k = 0; k < 3; k++) begin
        us_r[k] <= MW'(signed'(uvwd_r[QW][k*DIF +: DIF])) * MW'(signed'({1'b0, qs_r[QW]}));
        vt_r[k] <= MW'(signed'(uvwd_r[QW][(3+k)*DIF +: DIF])) *
                   MW'(signed'({1'b0, qt_r[QW]}));
        wm_r[k] <= signed'(uvwd_r[QW][(6+k)*DIF +: DIF]);
        p_r[k]  <= accs[k][PKW-1:0];
        sq_r[k] <= (2*PKW)'(p_r[k]) * (2*PKW)'(p_r[k]);
      end
    end
  end

  // square root stages, one result bit each
  logic [SW-1:0] op_r  [NR+1];
  logic [SW-1:0] res_r [NR+1];
  logic [NR:0]   vq_r;

  always_ff @(posedge clk) begin
    if (enb) begin
      op_r[0]  <= SW'(unsigned'(sq_r[0])) + SW'(unsigned'(sq_r[1])) +
                  SW'(unsigned'(sq_r[2]));
      res_r[0] <= '0;
    end
  end

  for (genvar j = 1; j <= NR; j++) begin : g_sqrt
    localparam logic [SW-1:0] ONE = {{(SW-1){1'b0}}, 1'b1} << (SW - 2*j);
    logic [SW-1:0] trial;
    assign trial = res_r[j-1] + ONE;

    always_ff @(posedge clk) begin
      if (enb) begin
        if (op_r[j-1] >= trial) begin
          op_r[j]  <= op_r[j-1] - trial;
          res_r[j] <= (res_r[j-1] >> 1) + ONE;
        end else begin
          op_r[j]  <= op_r[j-1];
          res_r[j] <= res_r[j-1] >> 1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (enb) begin
      if (res_r[NR] > SW'(OUT_MAX)) begin
        out_data_r <= OUT_MAX;
      end else begin
        out_data_r <= res_r[NR][OUT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r        <= '0;
      vm_r        <= 1'b0;
      va_r        <= 1'b0;
      vs_r        <= 1'b0;
      vq_r        <= '0;
      out_valid_r <= 1'b0;
    end else if (enb) begin
      vd_r        <= {vd_r[QW-1:0], pop};
      vm_r        <= vd_r[QW];
      va_r        <= vm_r;
      vs_r        <= va_r;
      vq_r        <= {vq_r[NR-1:0], vs_r};
      out_valid_r <= vq_r[NR];
    end
  end

endmodule

// ===== tb/tb_segment_segment_distance_top.sv =====
// Testbench for segment_segment_distance_top: random and directed segment pairs,
// checked against a wide-integer predictor. Depends on ssd_pkg, ssd_if and segment_segment_distance_top.
`timescale 1ns / 1ps
module tb_segment_segment_distance_top import ssd_pkg::*; ();

  localparam int CW        = 24;
  localparam int N_RANDOM  = 730;
  localparam int CYC_LIMIT = 400000;

  typedef logic signed [CW-1:0] crd_t;
  typedef logic signed [255:0] big_t;
  typedef struct {
    crd_t c[12];
  } seg_pair_t;

  logic clk;
  logic rst_n;
  ssd_in_if #(.COORD_BITS(CW)) in_ch ();
  ssd_out_if out_ch ();

  segment_segment_distance_top #(.COORD_BITS(CW)) uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  seg_pair_t           pending_pairs[$];
  logic [OUT_W-1:0]    expected_dist[$];
  int                  mismatches;
  int                  cycle;
  int                  pairs_accepted;
  int                  holdoff_left;
  bit                  holdoff_done;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // floor(n * 2^32 / d), zero for non-positive operands, capped at one
  function automatic big_t frac_q32(big_t n, big_t d);
    big_t q;
    if (n <= 0 || d <= 0) return '0;
    q = (n <<< SC_FRAC) / d;
    if (q > (big_t'(1) <<< SC_FRAC)) q = big_t'(1) <<< SC_FRAC;
    return q;
  endfunction

  function automatic void choose_s(big_t m, big_t a, inout big_t sn, inout big_t sd);
    if (m < 0) sn = '0;
    else if (m > a) sn = sd;
    else begin
      sn = m;
      sd = a;
    end
  endfunction

  function automatic logic [OUT_W-1:0] closest_dist(seg_pair_t p);
    big_t u[3], v[3], w[3];
    big_t a, b, c, d, e, dd, sn, sd, tn, td, sc, tc, sum, pv;
    logic [63:0] root, cand;
    for (int k = 0; k < 3; k++) begin
      u[k] = big_t'(p.c[3+k]) - big_t'(p.c[k]);
      v[k] = big_t'(p.c[9+k]) - big_t'(p.c[6+k]);
      w[k] = big_t'(p.c[k]) - big_t'(p.c[6+k]);
    end
    a = u[0]*u[0] + u[1]*u[1] + u[2]*u[2];
    b = u[0]*v[0] + u[1]*v[1] + u[2]*v[2];
    c = v[0]*v[0] + v[1]*v[1] + v[2]*v[2];
    d = u[0]*w[0] + u[1]*w[1] + u[2]*w[2];
    e = v[0]*w[0] + v[1]*w[1] + v[2]*w[2];
    dd = a*c - b*b;
    if (dd <= 0) begin
      sn = '0; sd = 1; tn = e; td = c;
    end else begin
      sd = dd; td = dd;
      sn = b*e - c*d;
      tn = a*e - b*d;
      if (sn < 0) begin
        sn = '0; tn = e; td = c;
      end else if (sn > sd) begin
        sn = sd; tn = e + b; td = c;
      end
    end
    if (tn < 0) begin
      tn = '0;
      choose_s(-d, a, sn, sd);
    end else if (tn > td) begin
      tn = td;
      choose_s(b - d, a, sn, sd);
    end
    sc = frac_q32(sn, sd);
    tc = frac_q32(tn, td);
    sum = '0;
    for (int k = 0; k < 3; k++) begin
      pv = ((w[k] <<< SC_FRAC) + u[k]*sc - v[k]*tc) >>> SC_FRAC;
      sum += pv * pv;
    end
    root = '0;
    for (int bt = 62; bt >= 0; bt--) begin
      cand = root | (64'd1 << bt);
      if (big_t'(cand) * big_t'(cand) <= sum) root = cand;
    end
    if (root > 64'(OUT_MAX)) root = 64'(OUT_MAX);
    return root[OUT_W-1:0];
  endfunction

  function automatic crd_t rand_crd(int span);
    if (span == 0) return crd_t'($urandom);
    return crd_t'($signed($urandom_range(0, 2*span)) - span);
  endfunction

  task automatic add_pair(crd_t vals[12]);
    seg_pair_t p;
    p.c = vals;
    pending_pairs.push_back(p);
  endtask

  task automatic add_random_pair();
    crd_t vals[12];
    int   span, shape;
    span  = ($urandom_range(0, 9) < 3) ? 0 : (1 << $urandom_range(4, 22));
    shape = $urandom_range(0, 9);
    for (int i = 0; i < 12; i++) vals[i] = rand_crd(span);
    case (shape)
      0: begin  // near-parallel: B's ends are A's ends plus a quarter of B's start
        for (int i = 0; i < 6; i++) vals[6+i] = vals[i] + vals[6 + (i % 3)] / 4;
      end
      1: begin  // degenerate: one endpoint pair collapses
        for (int i = 0; i < 3; i++) vals[9+i] = vals[6+i];
      end
      2: begin  // shared endpoint
        for (int i = 0; i < 3; i++) vals[6+i] = vals[3+i];
      end
      3: begin  // anti-parallel: B is A reversed and offset
        for (int i = 0; i < 3; i++) begin
          vals[6+i] = vals[3+i] + crd_t'($signed($urandom_range(0, 64)) - 32);
          vals[9+i] = vals[i] + crd_t'($signed($urandom_range(0, 64)) - 32);
        end
      end
      default: ;
    endcase
    add_pair(vals);
  endtask

  task automatic add_directed();
    crd_t vals[12];
    crd_t mx, mn;
    mx = {1'b0, {(CW-1){1'b1}}};
    mn = {1'b1, {(CW-1){1'b0}}};
    vals = '{default: '0};                       add_pair(vals);
    vals = '{default: mx};                       add_pair(vals);
    vals = '{default: mn};                       add_pair(vals);
    vals = '{mn, mn, mn, mx, mx, mx, mx, mn, mx, mn, mx, mn}; add_pair(vals);
    vals = '{mx, mx, mx, mn, mn, mn, mn, mn, mn, mx, mx, mx}; add_pair(vals);
    vals = '{mn, mx, mn, mx, mn, mx, mx, mx, mx, mn, mn, mn}; add_pair(vals);
    // both segments collapsed to points
    vals = '{256, 512, -768, 256, 512, -768, 0, 0, 0, 0, 0, 0}; add_pair(vals);
    // one point, one segment
    vals = '{0, 0, 0, 2560, 0, 0, 1280, 512, 0, 1280, 512, 0}; add_pair(vals);
    // crossing in the middle
    vals = '{-1024, 0, 0, 1024, 0, 0, 0, -1024, 256, 0, 1024, 256}; add_pair(vals);
    // parallel overlapping, parallel disjoint, anti-parallel
    vals = '{0, 0, 0, 2048, 0, 0, 512, 256, 0, 2560, 256, 0}; add_pair(vals);
    vals = '{0, 0, 0, 256, 0, 0, 1024, 256, 0, 2048, 256, 0}; add_pair(vals);
    vals = '{0, 0, 0, 2048, 0, 0, 2048, 256, 0, 0, 256, 0}; add_pair(vals);
    // clamps: closest point beyond each end of either segment
    vals = '{0, 0, 0, 256, 0, 0, 2048, -512, 0, 2048, 512, 0}; add_pair(vals);
    vals = '{0, 0, 0, 256, 0, 0, -2048, -512, 0, -2048, 512, 0}; add_pair(vals);
    vals = '{-512, 0, 0, 512, 0, 0, 0, 256, 256, 0, 2048, 2048}; add_pair(vals);
    vals = '{-512, 0, 0, 512, 0, 0, 0, -2048, 256, 0, -256, 256}; add_pair(vals);
    vals = '{0, 0, 0, 1024, 1024, 0, 2048, 0, 512, 4096, 4096, 512}; add_pair(vals);
    vals = '{1, -1, 1, -1, 1, -1, 1, 1, -1, -1, -1, 1}; add_pair(vals);
    // shared endpoint, identical segments
    vals = '{0, 0, 0, 768, 0, 0, 768, 0, 0, 768, 768, 0}; add_pair(vals);
    vals = '{100, 200, 300, 400, 500, 600, 100, 200, 300, 400, 500, 600}; add_pair(vals);
    // perpendicular, far apart in z
    vals = '{0, 0, mn, 256, 0, mn, 0, 0, mx, 0, 256, mx}; add_pair(vals);
  endtask

  // source side
  always @(posedge clk) begin
    seg_pair_t p;
    bit        quiet;
    // no idling on either side while this window of words goes through
    quiet = (pairs_accepted >= 400 && pairs_accepted < 600);
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        for (int i = 0; i < 12; i++) p.c[i] = crd_t'(0);
        p.c = '{in_ch.seg_a_start_x, in_ch.seg_a_start_y, in_ch.seg_a_start_z,
                in_ch.seg_a_end_x, in_ch.seg_a_end_y, in_ch.seg_a_end_z,
                in_ch.seg_b_start_x, in_ch.seg_b_start_y, in_ch.seg_b_start_z,
                in_ch.seg_b_end_x, in_ch.seg_b_end_y, in_ch.seg_b_end_z};
        expected_dist.push_back(closest_dist(p));
        pairs_accepted <= pairs_accepted + 1;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_pairs.size() > 0 && (quiet || $urandom_range(0, 99) >= 19)) begin
          p = pending_pairs.pop_front();
          in_ch.seg_a_start_x <= p.c[0];
          in_ch.seg_a_start_y <= p.c[1];
          in_ch.seg_a_start_z <= p.c[2];
          in_ch.seg_a_end_x   <= p.c[3];
          in_ch.seg_a_end_y   <= p.c[4];
          in_ch.seg_a_end_z   <= p.c[5];
          in_ch.seg_b_start_x <= p.c[6];
          in_ch.seg_b_start_y <= p.c[7];
          in_ch.seg_b_start_z <= p.c[8];
          in_ch.seg_b_end_x   <= p.c[9];
          in_ch.seg_b_end_y   <= p.c[10];
          in_ch.seg_b_end_z   <= p.c[11];
          in_ch.valid <= 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // long output hold-off once traffic is flowing, so the queue fills up
  always @(posedge clk) begin
    if (!rst_n) begin
      holdoff_left <= 0;
      holdoff_done <= 1'b0;
    end else if (!holdoff_done && pairs_accepted >= 200) begin
      holdoff_left <= 400;
      holdoff_done <= 1'b1;
    end else if (holdoff_left > 0) begin
      holdoff_left <= holdoff_left - 1;
    end
  end

  // sink side
  always @(posedge clk) begin
    logic [OUT_W-1:0] want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (holdoff_left > 0) out_ch.ready <= 1'b0;
      else if (pairs_accepted >= 400 && pairs_accepted < 600) out_ch.ready <= 1'b1;
      else out_ch.ready <= ($urandom_range(0, 99) >= 19);
      if (out_ch.valid && out_ch.ready) begin
        if (expected_dist.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("unexpected distance word %0d", out_ch.closest_distance);
        end else begin
          want = expected_dist.pop_front();
          if (out_ch.closest_distance !== want) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10)
              $display("closest_distance mismatch: expected %0d, got %0d",
                       want, out_ch.closest_distance);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle == CYC_LIMIT) begin
      $display("segment_segment_distance_top regression: fail");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    cycle = 0;
    mismatches = 0;
    pairs_accepted = 0;
    in_ch.valid = 1'b0;
    {in_ch.seg_a_start_x, in_ch.seg_a_start_y, in_ch.seg_a_start_z} = '0;
    {in_ch.seg_a_end_x, in_ch.seg_a_end_y, in_ch.seg_a_end_z} = '0;
    {in_ch.seg_b_start_x, in_ch.seg_b_start_y, in_ch.seg_b_start_z} = '0;
    {in_ch.seg_b_end_x, in_ch.seg_b_end_y, in_ch.seg_b_end_z} = '0;
    out_ch.ready = 1'b0;
    add_directed();
    for (int i = 0; i < N_RANDOM; i++) add_random_pair();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    // drain: everything sent, accepted and returned
    while (pending_pairs.size() > 0 || in_ch.valid || expected_dist.size() > 0)
      @(posedge clk);
    repeat (150) @(posedge clk);
    if (mismatches == 0 && expected_dist.size() == 0)
      $display("segment_segment_distance_top regression: pass");
    else
      $display("segment_segment_distance_top regression: fail");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/ssd_pkg.sv
sv/ssd_if.sv
sv/ssd_front.sv
sv/ssd_fifo.sv
sv/ssd_back.sv
sv/segment_segment_distance_top.sv
tb/tb_segment_segment_distance_top.sv
